@@ design/tcspl_pkg.sv @@
// Shared types and constants for the two-class sorted priority list.
`timescale 1ns / 1ps

package tcspl_pkg;

    localparam int KEY_W = 16;
    localparam int TAG_W = 16;
    localparam int CNT_W = 7;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    // Report steps, one memory read each.
    localparam logic [1:0] STEP_HEAD  = 2'd0;
    localparam logic [1:0] STEP_LAST  = 2'd1;
    localparam logic [1:0] STEP_GUEST = 2'd2;
    localparam logic [1:0] STEP_TAIL  = 2'd3;

    typedef struct packed {
        logic             member;
        logic [KEY_W-1:0] minutes;
        logic [TAG_W-1:0] tag;
    } t_slot;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             dropped;
        logic [TAG_W-1:0] head_tag;
        logic [KEY_W-1:0] head_minutes;
        logic             last_member_valid;
        logic [TAG_W-1:0] last_member_tag;
        logic             first_guest_valid;
        logic [TAG_W-1:0] first_guest_tag;
        logic [TAG_W-1:0] tail_tag;
    } t_result;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_WRITE_NEW,
        ST_RPT_READ,
        ST_RPT_CAPTURE,
        ST_DONE
    } t_state;

endpackage

@@ design/two_class_sorted_priority_list_core.sv @@
// Top level of the two-class sorted priority list.
`timescale 1ns / 1ps

// The list lives in one slot memory in list order, members first, each class sorted by
// ascending minutes. An insert walks backward from the tail, reading one slot and writing
// it one place up until it meets the slot that the new entry follows, then writes the new
// entry; a clear or a refused insert skips that walk. Every transaction then reads the
// memory once each for head, last member, first guest and tail. All of these reads share
// the single memory read port. One transaction is worked on at a time; a finished result
// waits in the output register while the next input is taken.
// There is no clearing pass after reset.

module two_class_sorted_priority_list_core #(
    parameter int LIST_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_op,
    input  logic        i_entry_member,
    input  logic [15:0] i_entry_minutes,
    input  logic [15:0] i_entry_tag,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [6:0]  o_count,
    output logic        o_dropped,
    output logic [15:0] o_head_tag,
    output logic [15:0] o_head_minutes,
    output logic        o_last_member_valid,
    output logic [15:0] o_last_member_tag,
    output logic        o_first_guest_valid,
    output logic [15:0] o_first_guest_tag,
    output logic [15:0] o_tail_tag
);

    localparam int AW = $clog2(LIST_DEPTH);
    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam logic [CW-1:0] FULL = CW'(LIST_DEPTH);

    tcspl_pkg::t_state  r_state, n_state;
    logic [CW-1:0]      r_idx, n_idx;
    logic [CW-1:0]      r_fill, n_fill;
    logic [CW-1:0]      r_members, n_members;
    logic [1:0]         r_step, n_step;
    logic               r_dropped, n_dropped;
    tcspl_pkg::t_slot   r_new, n_new;
    tcspl_pkg::t_result r_res, n_res;
    tcspl_pkg::t_result r_out, n_out;
    logic               r_out_valid, n_out_valid;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    tcspl_pkg::t_slot   ram_wdata;
    logic [AW-1:0]      ram_raddr;
    tcspl_pkg::t_slot   ram_rdata;

    logic               step_valid;
    logic [CW-1:0]      step_pos;
    logic               precedes;

    tcspl_ram #(
        .DEPTH (LIST_DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Which slot a report step looks at, and whether that slot exists.
    always_comb begin
        case (r_step)
            tcspl_pkg::STEP_HEAD: begin
                step_valid = (r_fill != '0);
                step_pos   = '0;
            end
            tcspl_pkg::STEP_LAST: begin
                step_valid = (r_members != '0);
                step_pos   = r_members - CW'(1);
            end
            tcspl_pkg::STEP_GUEST: begin
                step_valid = (r_members < r_fill);
                step_pos   = r_members;
            end
            tcspl_pkg::STEP_TAIL: begin
                step_valid = (r_fill != '0);
                step_pos   = r_fill - CW'(1);
            end
            default: begin
                step_valid = 1'b0;
                step_pos   = '0;
            end
        endcase
    end

    // The new entry goes in front of the slot just read when that slot is a guest and the
    // new one a member, or both share a class and the slot's key is not smaller.
    assign precedes = (r_new.member & ~ram_rdata.member) |
                      ((r_new.member == ram_rdata.member) &
                       (ram_rdata.minutes >= r_new.minutes));

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_fill      = r_fill;
        n_members   = r_members;
        n_step      = r_step;
        n_dropped   = r_dropped;
        n_new       = r_new;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        ram_we      = 1'b0;
        ram_waddr   = r_idx[AW-1:0];
        ram_wdata   = r_new;
        ram_raddr   = '0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            tcspl_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_step    = tcspl_pkg::STEP_HEAD;
                    n_dropped = 1'b0;
                    if (i_op == tcspl_pkg::OP_CLEAR) begin
                        n_fill    = '0;
                        n_members = '0;
                        n_state   = tcspl_pkg::ST_RPT_READ;
                    end else if (r_fill >= FULL) begin
                        n_dropped = 1'b1;
                        n_state   = tcspl_pkg::ST_RPT_READ;
                    end else begin
                        n_new.member  = i_entry_member;
                        n_new.minutes = i_entry_minutes;
                        n_new.tag     = i_entry_tag;
                        n_idx         = r_fill;
                        n_state       = tcspl_pkg::ST_READ;
                    end
                end
            end
            tcspl_pkg::ST_READ: begin
                ram_raddr = AW'(r_idx - CW'(1));
                if (r_idx == '0) begin
                    n_state = tcspl_pkg::ST_WRITE_NEW;
                end else begin
                    n_state = tcspl_pkg::ST_CHECK;
                end
            end
            tcspl_pkg::ST_CHECK: begin
                if (precedes) begin
                    ram_we    = 1'b1;
                    ram_wdata = ram_rdata;
                    n_idx     = r_idx - CW'(1);
                    n_state   = tcspl_pkg::ST_READ;
                end else begin
                    n_state = tcspl_pkg::ST_WRITE_NEW;
                end
            end
            tcspl_pkg::ST_WRITE_NEW: begin
                ram_we    = 1'b1;
                n_fill    = r_fill + CW'(1);
                n_members = r_members + CW'(r_new.member);
                n_state   = tcspl_pkg::ST_RPT_READ;
            end
            tcspl_pkg::ST_RPT_READ: begin
                ram_raddr = step_valid ? step_pos[AW-1:0] : '0;
                n_state   = tcspl_pkg::ST_RPT_CAPTURE;
            end
            tcspl_pkg::ST_RPT_CAPTURE: begin
                case (r_step)
                    tcspl_pkg::STEP_HEAD: begin
                        n_res.head_tag     = step_valid ? ram_rdata.tag : '0;
                        n_res.head_minutes = step_valid ? ram_rdata.minutes : '0;
                    end
                    tcspl_pkg::STEP_LAST: begin
                        n_res.last_member_valid = step_valid;
                        n_res.last_member_tag   = step_valid ? ram_rdata.tag : '0;
                    end
                    tcspl_pkg::STEP_GUEST: begin
                        n_res.first_guest_valid = step_valid;
                        n_res.first_guest_tag   = step_valid ? ram_rdata.tag : '0;
                    end
                    default: begin
                        n_res.tail_tag = step_valid ? ram_rdata.tag : '0;
                    end
                endcase
                n_res.count   = tcspl_pkg::CNT_W'(r_fill);
                n_res.dropped = r_dropped;
                if (r_step == tcspl_pkg::STEP_TAIL) begin
                    n_state = tcspl_pkg::ST_DONE;
                end else begin
                    n_step  = r_step + 2'd1;
                    n_state = tcspl_pkg::ST_RPT_READ;
                end
            end
            tcspl_pkg::ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = tcspl_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tcspl_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tcspl_pkg::ST_IDLE;
            r_fill      <= '0;
            r_members   <= '0;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
            r_step      <= '0;
            r_dropped   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_members   <= n_members;
            r_out_valid <= n_out_valid;
            r_idx       <= n_idx;
            r_step      <= n_step;
            r_dropped   <= n_dropped;
        end
    end

    always_ff @(posedge i_clk) begin
        r_new <= n_new;
        r_res <= n_res;
        r_out <= n_out;
    end

    assign o_in_ready          = (r_state == tcspl_pkg::ST_IDLE);
    assign o_out_valid         = r_out_valid;
    assign o_count             = r_out.count;
    assign o_dropped           = r_out.dropped;
    assign o_head_tag          = r_out.head_tag;
    assign o_head_minutes      = r_out.head_minutes;
    assign o_last_member_valid = r_out.last_member_valid;
    assign o_last_member_tag   = r_out.last_member_tag;
    assign o_first_guest_valid = r_out.first_guest_valid;
    assign o_first_guest_tag   = r_out.first_guest_tag;
    assign o_tail_tag          = r_out.tail_tag;

endmodule

@@ design/tcspl_ram.sv @@
// Simple dual-port slot memory with one write port and a registered read port.
`timescale 1ns / 1ps

module tcspl_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [AW-1:0]      i_waddr,
    input  tcspl_pkg::t_slot   i_wdata,
    input  logic [AW-1:0]      i_raddr,
    output tcspl_pkg::t_slot   o_rdata
);

    tcspl_pkg::t_slot r_mem [DEPTH];
    tcspl_pkg::t_slot r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for the two-class sorted priority list core.
`timescale 1ns / 1ps

module testbench;

    localparam int DEPTH        = 64;
    localparam int RANDOM_ITEMS = 1000;
    localparam int DRAIN_CYCLES = 2 * DEPTH + 40;
    localparam int CYCLE_LIMIT  = 1_000_000;

    typedef struct {
        logic                        op;
        logic                        member;
        logic [tcspl_pkg::KEY_W-1:0] minutes;
        logic [tcspl_pkg::TAG_W-1:0] tag;
        int                          reps;
        bit                          typed;
        tcspl_pkg::t_result          report;
    } t_dir_row;

    logic                        clk;
    logic                        rst_n = 1'b0;
    logic                        in_valid = 1'b0;
    logic                        in_ready;
    logic                        op = tcspl_pkg::OP_INSERT;
    logic                        entry_member = 1'b0;
    logic [tcspl_pkg::KEY_W-1:0] entry_minutes = '0;
    logic [tcspl_pkg::TAG_W-1:0] entry_tag = '0;
    logic                        out_valid;
    logic                        out_ready = 1'b0;
    tcspl_pkg::t_result          seen;

    // Predictor state: the list in order, and how many entries it holds.
    tcspl_pkg::t_slot            sorted_slots [DEPTH];
    int                          slots_held;
    tcspl_pkg::t_result          pending_reports [$];
    t_dir_row                    dir_rows [$];

    int unsigned      cycle_count;
    int unsigned      errors;
    int unsigned      reports_seen;
    int unsigned      burst_left;
    int unsigned      items_sent;
    int unsigned      inserts_sent;
    int unsigned      clears_sent;
    int unsigned      drops_seen;
    int unsigned      full_hits;
    logic [31:0]      ready_pattern;
    int unsigned      ready_phase;

    two_class_sorted_priority_list_core #(
        .LIST_DEPTH(DEPTH)
    ) dut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_in_valid         (in_valid),
        .o_in_ready         (in_ready),
        .i_op               (op),
        .i_entry_member     (entry_member),
        .i_entry_minutes    (entry_minutes),
        .i_entry_tag        (entry_tag),
        .o_out_valid        (out_valid),
        .i_out_ready        (out_ready),
        .o_count            (seen.count),
        .o_dropped          (seen.dropped),
        .o_head_tag         (seen.head_tag),
        .o_head_minutes     (seen.head_minutes),
        .o_last_member_valid(seen.last_member_valid),
        .o_last_member_tag  (seen.last_member_tag),
        .o_first_guest_valid(seen.first_guest_valid),
        .o_first_guest_tag  (seen.first_guest_tag),
        .o_tail_tag         (seen.tail_tag)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count == CYCLE_LIMIT);
        $display("%0t ns: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    // Applies one transaction to the predicted list and returns the report it yields.
    function automatic tcspl_pkg::t_result apply_list_op(
        input logic is_clear, input logic mem,
        input logic [tcspl_pkg::KEY_W-1:0] key,
        input logic [tcspl_pkg::TAG_W-1:0] tag);
        tcspl_pkg::t_result rpt;
        int                 pos;
        int                 members;
        rpt = '0;
        pos = 0;
        members = 0;
        if (is_clear == tcspl_pkg::OP_CLEAR) begin
            slots_held = 0;
        end else if (slots_held >= DEPTH) begin
            rpt.dropped = 1'b1;
        end else begin
            // Members never look past the member block; guests skip it first.
            if (mem) begin
                while (pos < slots_held && sorted_slots[pos].member
                       && sorted_slots[pos].minutes < key)
                    pos++;
            end else begin
                while (pos < slots_held && sorted_slots[pos].member)
                    pos++;
                while (pos < slots_held && !sorted_slots[pos].member
                       && sorted_slots[pos].minutes < key)
                    pos++;
            end
            for (int i = slots_held; i > pos; i--)
                sorted_slots[i] = sorted_slots[i-1];
            sorted_slots[pos] = tcspl_pkg::t_slot'{member: mem, minutes: key, tag: tag};
            slots_held++;
        end
        while (members < slots_held && sorted_slots[members].member)
            members++;
        rpt.count = tcspl_pkg::CNT_W'(slots_held);
        if (slots_held > 0) begin
            rpt.head_tag     = sorted_slots[0].tag;
            rpt.head_minutes = sorted_slots[0].minutes;
            rpt.tail_tag     = sorted_slots[slots_held-1].tag;
        end
        if (members > 0) begin
            rpt.last_member_valid = 1'b1;
            rpt.last_member_tag   = sorted_slots[members-1].tag;
        end
        if (members < slots_held) begin
            rpt.first_guest_valid = 1'b1;
            rpt.first_guest_tag   = sorted_slots[members].tag;
        end
        return rpt;
    endfunction

    // Offers one transaction, in bursts with random gaps, and records its expected report.
    task automatic send_item(input logic op_v, input logic mem,
                             input logic [tcspl_pkg::KEY_W-1:0] key,
                             input logic [tcspl_pkg::TAG_W-1:0] tag, input bit typed,
                             input tcspl_pkg::t_result typed_report);
        tcspl_pkg::t_result predicted;
        if (burst_left == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150)
                                                     : $urandom_range(1, 10);
        end
        in_valid      <= 1'b1;
        op            <= op_v;
        entry_member  <= mem;
        entry_minutes <= key;
        entry_tag     <= tag;
        do @(posedge clk); while (!in_ready);
        burst_left--;
        predicted = apply_list_op(op_v, mem, key, tag);
        pending_reports.push_back(typed ? typed_report : predicted);
        items_sent++;
        if (op_v == tcspl_pkg::OP_CLEAR) clears_sent++;
        else inserts_sent++;
        if (predicted.dropped) drops_seen++;
        if (slots_held == DEPTH && predicted.count == tcspl_pkg::CNT_W'(DEPTH)
            && !predicted.dropped)
            full_hits++;
    endtask

    // Receiver stalls follow a random 32-bit pattern that is redrawn each time it runs out.
    always @(posedge clk) begin
        if (ready_phase == 0) begin
            case ($urandom_range(0, 3))
                0: ready_pattern = '1;
                1: ready_pattern = $urandom | $urandom;
                2: ready_pattern = $urandom;
                default: ready_pattern = $urandom & $urandom;
            endcase
        end
        out_ready <= ready_pattern[ready_phase];
        ready_phase = (ready_phase + 1) % 32;
    end

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t ns: report %0d %s expected 0x%0h, got 0x%0h",
                     $time, reports_seen, name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk) begin
        tcspl_pkg::t_result want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_reports.size() == 0) begin
                $display("%0t ns: report %0d expected none, got count 0x%0h head 0x%0h",
                         $time, reports_seen, seen.count, seen.head_tag);
                errors++;
            end else begin
                want = pending_reports.pop_front();
                check_field("count", 32'(want.count), 32'(seen.count));
                check_field("dropped", 32'(want.dropped), 32'(seen.dropped));
                check_field("head_tag", 32'(want.head_tag), 32'(seen.head_tag));
                check_field("head_minutes", 32'(want.head_minutes),
                            32'(seen.head_minutes));
                check_field("last_member_valid", 32'(want.last_member_valid),
                            32'(seen.last_member_valid));
                check_field("last_member_tag", 32'(want.last_member_tag),
                            32'(seen.last_member_tag));
                check_field("first_guest_valid", 32'(want.first_guest_valid),
                            32'(seen.first_guest_valid));
                check_field("first_guest_tag", 32'(want.first_guest_tag),
                            32'(seen.first_guest_tag));
                check_field("tail_tag", 32'(want.tail_tag), 32'(seen.tail_tag));
            end
            reports_seen++;
        end
    end

    initial begin
        tcspl_pkg::t_result          empty_rpt;
        t_dir_row                    row;
        int                          run_len;
        int                          key_mode;
        int                          member_odds;
        logic [tcspl_pkg::KEY_W-1:0] key;

        empty_rpt = '0;
        slots_held = 0;

        // Directed rows; a report is typed in only where it is obvious.
        dir_rows.push_back('{tcspl_pkg::OP_CLEAR, 1'b0, 16'h0000, 16'h0000, 1, 1'b1,
                             empty_rpt});
        dir_rows.push_back('{tcspl_pkg::OP_INSERT, 1'b0, 16'hFFFF, 16'hFFFF, 1, 1'b1,
            tcspl_pkg::t_result'{count: 7'd1, dropped: 1'b0, head_tag: 16'hFFFF,
                      head_minutes: 16'hFFFF, last_member_valid: 1'b0,
                      last_member_tag: 16'h0000, first_guest_valid: 1'b1,
                      first_guest_tag: 16'hFFFF, tail_tag: 16'hFFFF}});
        dir_rows.push_back('{tcspl_pkg::OP_INSERT, 1'b1, 16'h0000, 16'h0000, 1, 1'b0,
                             empty_rpt});
        dir_rows.push_back('{tcspl_pkg::OP_INSERT, 1'b1, 16'h8000, 16'h1234, 1, 1'b0,
                             empty_rpt});
        // Equal keys: the newer entry goes in front of the older one.
        dir_rows.push_back('{tcspl_pkg::OP_INSERT, 1'b1, 16'h8000, 16'h1235, 1, 1'b0,
                             empty_rpt});
        dir_rows.push_back('{tcspl_pkg::OP_INSERT, 1'b0, 16'h0000, 16'hAAAA, 1, 1'b0,
                             empty_rpt});
        dir_rows.push_back('{tcspl_pkg::OP_INSERT, 1'b0, 16'hFFFF, 16'h5555, 1, 1'b0,
                             empty_rpt});
        dir_rows.push_back('{tcspl_pkg::OP_INSERT, 1'b1, 16'hFFFF, 16'h0F0F, 1, 1'b0,
                             empty_rpt});
        dir_rows.push_back('{tcspl_pkg::OP_CLEAR, 1'b1, 16'hFFFF, 16'hFFFF, 1, 1'b1,
                             empty_rpt});
        dir_rows.push_back('{tcspl_pkg::OP_INSERT, 1'b1, 16'h1234, 16'hBEEF, 1, 1'b0,
                             empty_rpt});
        dir_rows.push_back('{tcspl_pkg::OP_INSERT, 1'b1, 16'h0100, 16'h0001, 1, 1'b0,
                             empty_rpt});
        dir_rows.push_back('{tcspl_pkg::OP_CLEAR, 1'b0, 16'h0000, 16'h0000, 1, 1'b1,
                             empty_rpt});
        dir_rows.push_back('{tcspl_pkg::OP_INSERT, 1'b0, 16'h4000, 16'h2222, 1, 1'b0,
                             empty_rpt});
        // Fill the list to one short of full, then fill it and push against the limit.
        dir_rows.push_back('{tcspl_pkg::OP_INSERT, 1'b0, 16'h4000, 16'h3000, DEPTH - 2,
                             1'b0, empty_rpt});
        dir_rows.push_back('{tcspl_pkg::OP_INSERT, 1'b1, 16'h0000, 16'hC0DE, 1, 1'b0,
                             empty_rpt});
        dir_rows.push_back('{tcspl_pkg::OP_INSERT, 1'b0, 16'h0000, 16'h7777, 1, 1'b0,
                             empty_rpt});
        dir_rows.push_back('{tcspl_pkg::OP_INSERT, 1'b1, 16'hFFFF, 16'hFFFF, 1, 1'b0,
                             empty_rpt});
        dir_rows.push_back('{tcspl_pkg::OP_CLEAR, 1'b0, 16'h5A5A, 16'hA5A5, 1, 1'b1,
                             empty_rpt});
        dir_rows.push_back('{tcspl_pkg::OP_INSERT, 1'b1, 16'h0000, 16'h0000, 1, 1'b1,
            tcspl_pkg::t_result'{count: 7'd1, dropped: 1'b0, head_tag: 16'h0000,
                      head_minutes: 16'h0000, last_member_valid: 1'b1,
                      last_member_tag: 16'h0000, first_guest_valid: 1'b0,
                      first_guest_tag: 16'h0000, tail_tag: 16'h0000}});

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[r]) begin
            row = dir_rows[r];
            for (int k = 0; k < row.reps; k++)
                send_item(row.op, row.member, row.minutes,
                          row.tag + tcspl_pkg::TAG_W'(k), row.typed, row.report);
        end

        // Random part: mostly a clear followed by a run of inserts, with some stray items.
        while (items_sent < RANDOM_ITEMS + 80) begin
            if ($urandom_range(0, 7) == 0) begin
                send_item(logic'($urandom_range(0, 1)), logic'($urandom_range(0, 1)),
                          tcspl_pkg::KEY_W'($urandom), tcspl_pkg::TAG_W'($urandom), 1'b0,
                          empty_rpt);
            end else begin
                send_item(tcspl_pkg::OP_CLEAR, logic'($urandom_range(0, 1)),
                          tcspl_pkg::KEY_W'($urandom), tcspl_pkg::TAG_W'($urandom), 1'b0,
                          empty_rpt);
                run_len = ($urandom_range(0, 3) == 0) ? $urandom_range(DEPTH - 4, DEPTH + 8)
                                                      : $urandom_range(1, 30);
                key_mode = $urandom_range(0, 2);
                member_odds = $urandom_range(0, 4);
                for (int k = 0; k < run_len; k++) begin
                    // Narrow key ranges give many ties within a class.
                    case (key_mode)
                        0: key = tcspl_pkg::KEY_W'($urandom_range(0, 3));
                        1: key = tcspl_pkg::KEY_W'($urandom_range(0, 255));
                        default: key = tcspl_pkg::KEY_W'($urandom);
                    endcase
                    send_item(tcspl_pkg::OP_INSERT,
                              logic'($urandom_range(0, 3) < member_odds), key,
                              tcspl_pkg::TAG_W'($urandom), 1'b0, empty_rpt);
                end
            end
        end
        in_valid <= 1'b0;

        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d transactions: %0d inserts, %0d clears, %0d refused on a full list.",
                 items_sent, inserts_sent, clears_sent, drops_seen);
        $display("The list reached full depth %0d times; %0d reports checked, %0d errors.",
                 full_hits, reports_seen, errors);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

@@ files.f @@
design/tcspl_pkg.sv
design/tcspl_ram.sv
design/two_class_sorted_priority_list_core.sv
test/testbench.sv
